// ===== rtl/lst_pkg.sv =====
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants of the wavetable LFO track.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int LANES        = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int IDX_W        = 8;   // table position; covers tables up to 256 entries
  localparam int MASK_W       = 64;
  localparam int MASK_IX_W    = 6;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;

  localparam logic [6:0] TRACK_LENGTH_RESET = 7'd16;
  localparam logic [7:0] LAST_NONE          = 8'd255;

  localparam logic [3:0] PHASE_FIRST = 4'd0;
  localparam logic [3:0] PHASE_LAST  = 4'd11;

  localparam logic [1:0] MODE_FREE    = 2'd0;
  localparam logic [1:0] MODE_ONESHOT = 2'd2;

  localparam logic [2:0] WAVE_SINE      = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE  = 3'd1;
  localparam logic [2:0] WAVE_INV_RAMP  = 3'd4;
  localparam logic [2:0] WAVE_EXP       = 3'd5;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WAVE_SELECT   = 3'd0,
    CFG_SPEED_DIVIDER = 3'd1,
    CFG_LFO_MODE      = 3'd2,
    CFG_RETRIG_MASK   = 3'd3,
    CFG_TRACK_LENGTH  = 3'd4,
    CFG_OUTPUT_ENABLE = 3'd5,
    CFG_DEPTH_A       = 3'd6,
    CFG_DEPTH_B       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]        wave_select;
    logic [6:0]        speed_divider;
    logic [1:0]        lfo_mode;
    logic [MASK_W-1:0] retrig_mask;
    logic [6:0]        track_length;
    logic              output_enable;
    logic [6:0]        depth_a;
    logic [6:0]        depth_b;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [3:0] clock_phase;
    logic       lane_active_a;
    logic       lane_active_b;
    logic [6:0] base_a;
    logic [6:0] base_b;
    logic [1:0] table_select;
    logic [6:0] table_index;
    logic [7:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic       lane;
    logic [6:0] value;
    logic       last;
  } out_item_t;

  // Queue entry: a table write, or a tick with its lookup phase in tbl_idx.
  typedef struct packed {
    action_t          kind;
    logic [1:0]       tbl_sel;
    logic [IDX_W-1:0] tbl_idx;
    logic [7:0]       tbl_byte;
    logic [LANES-1:0] act;
    logic [6:0]       base_a;
    logic [6:0]       base_b;
  } qentry_t;

endpackage

// ===== rtl/lst_stream_if.sv =====
// ----------------------------------------------------------------------------
// lst_stream_if
// Valid/ready channel carrying one payload item per beat.
// ----------------------------------------------------------------------------
interface lst_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lst_queue.sv =====
// ----------------------------------------------------------------------------
// lst_queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lst_pkg::qentry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output lst_pkg::qentry_t head
);
  import lst_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end
endmodule

// ===== rtl/lst_front.sv =====
// ----------------------------------------------------------------------------
// lst_front
// Accepts items, runs the phase / divider / step sequencer and queues work.
// ----------------------------------------------------------------------------
module lst_front #(
  parameter int TABLE_LENGTH = 128,
  parameter int MAX_STEPS    = 64
) (
  input  logic              clk,
  input  logic              rst,
  lst_stream_if.sink        item_in,
  input  lst_pkg::cfg_t     cfg,
  input  logic              queue_full,
  output logic              push,
  output lst_pkg::qentry_t  push_entry
);
  import lst_pkg::*;

  localparam int PW = $clog2(TABLE_LENGTH);
  localparam int SW = $clog2(MAX_STEPS);

  logic [PW-1:0]        phase;
  logic [PW-1:0]        phase_next;
  logic [6:0]           hold;
  logic [6:0]           hold_next;
  logic [SW-1:0]        step;
  logic [SW-1:0]        step_next;

  logic                 accept;
  logic                 is_tick;
  logic                 retrig;
  logic [PW-1:0]        look;
  logic [6:0]           hold_inc;
  logic                 adv;
  logic [PW:0]          phase_sum;
  logic [MASK_IX_W-1:0] step_ix;
  logic [LANES-1:0]     act;
  logic                 idx_ok;

  assign item_in.ready = !queue_full;
  assign accept        = item_in.valid && item_in.ready;
  assign is_tick       = (action_t'(item_in.data.action) == ACT_TICK);

  always_comb begin
    step_ix = MASK_IX_W'(step);
    retrig  = (item_in.data.clock_phase == PHASE_FIRST) && (cfg.lfo_mode != MODE_FREE)
              && cfg.retrig_mask[step_ix];
    look    = retrig ? '0 : phase;

    // speed divider
    hold_inc = hold + 7'd1;
    if (cfg.speed_divider == '0) begin
      adv       = 1'b1;
      hold_next = hold;
    end else if (hold_inc >= cfg.speed_divider - 7'd1) begin
      adv       = 1'b1;
      hold_next = '0;
    end else begin
      adv       = 1'b0;
      hold_next = hold_inc;
    end

    phase_sum = {1'b0, look} + (PW+1)'(adv);
    if (phase_sum >= (PW+1)'(TABLE_LENGTH)) begin
      phase_next = (cfg.lfo_mode == MODE_ONESHOT) ? PW'(TABLE_LENGTH - 1) : '0;
    end else begin
      phase_next = phase_sum[PW-1:0];
    end

    // step counter
    if (item_in.data.clock_phase != PHASE_LAST) begin
      step_next = step;
    end else if (cfg.track_length != '0 && 7'(step) == cfg.track_length - 7'd1) begin
      step_next = '0;
    end else if (step == SW'(MAX_STEPS - 1)) begin
      step_next = '0;
    end else begin
      step_next = step + SW'(1);
    end
  end

  always_comb begin
    act    = {item_in.data.lane_active_b, item_in.data.lane_active_a}
             & {LANES{cfg.output_enable}};
    idx_ok = (int'(item_in.data.table_index) < TABLE_LENGTH);

    push_entry.kind     = is_tick ? ACT_TICK : ACT_WRITE;
    push_entry.tbl_sel  = item_in.data.table_select;
    push_entry.tbl_idx  = is_tick ? IDX_W'(look) : IDX_W'(item_in.data.table_index);
    push_entry.tbl_byte = item_in.data.table_value;
    push_entry.act      = act;
    push_entry.base_a   = item_in.data.base_a;
    push_entry.base_b   = item_in.data.base_b;

    // ticks with no lane to compute and out-of-range writes leave nothing to do
    push = accept && (is_tick ? (act != '0) : idx_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      hold  <= '0;
      step  <= '0;
    end else if (accept && is_tick) begin
      phase <= phase_next;
      hold  <= hold_next;
      step  <= step_next;
    end
  end
endmodule

// ===== rtl/lst_back.sv =====
// ----------------------------------------------------------------------------
// lst_back
// Wave table memory, lane scaling and change-only result emission.
// ----------------------------------------------------------------------------
module lst_back #(
  parameter int TABLE_LENGTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  lst_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  lst_pkg::qentry_t  q_head,
  output logic              q_pop,
  lst_stream_if.source      result_out
);
  import lst_pkg::*;

  localparam int PW    = $clog2(TABLE_LENGTH);
  localparam int AW    = PW + 2;
  localparam int DEPTH = 4 * (2 ** PW);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata;
  logic [1:0]        rd_tbl;
  logic              pop_tick;
  logic              pop_write;

  // compute stage
  logic              c_vld;
  logic [LANES-1:0]  c_act;
  logic [6:0]        c_base [LANES];

  // emit stage
  logic              e_vld;
  logic [LANES-1:0]  e_rem;
  logic [6:0]        e_val [LANES];
  logic [7:0]        last_val [LANES];

  logic              out_vld;
  out_item_t         out_data;

  logic signed [9:0]  sample;
  logic [6:0]         lane_depth [LANES];
  logic signed [17:0] prod [LANES];
  logic signed [17:0] quot [LANES];
  logic signed [10:0] sum [LANES];
  logic [6:0]         clamped [LANES];

  logic [LANES-1:0]  chg;
  logic              out_free;
  logic              emit;
  logic              emit_lane;
  logic              emit_last;
  logic              e_done;
  logic              e_take;

  // --- read / write stage ---
  always_comb begin
    rd_tbl = (cfg.wave_select == WAVE_INV_RAMP || cfg.wave_select == WAVE_EXP)
             ? 2'(cfg.wave_select - 3'd2) : cfg.wave_select[1:0];
    pop_write = q_valid && (q_head.kind == ACT_WRITE);
    pop_tick  = q_valid && (q_head.kind == ACT_TICK) && (!c_vld || e_take);
    q_pop     = pop_write || pop_tick;
  end

  always_ff @(posedge clk) begin
    if (pop_write) begin
      mem[{q_head.tbl_sel, q_head.tbl_idx[PW-1:0]}] <= q_head.tbl_byte;
    end
    if (pop_tick) begin
      rdata <= mem[AW'({rd_tbl, q_head.tbl_idx[PW-1:0]})];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_tick) begin
      c_act     <= q_head.act;
      c_base[0] <= q_head.base_a;
      c_base[1] <= q_head.base_b;
    end
  end

  // --- compute stage: centre or negate, scale by depth/128 toward zero, add base, clamp ---
  assign lane_depth[0] = cfg.depth_a;
  assign lane_depth[1] = cfg.depth_b;

  always_comb begin
    if (cfg.wave_select == WAVE_INV_RAMP || cfg.wave_select == WAVE_EXP) begin
      sample = -$signed({2'b00, rdata});
    end else if (cfg.wave_select == WAVE_SINE || cfg.wave_select == WAVE_TRIANGLE) begin
      sample = $signed({2'b00, rdata}) - 10'sd64;
    end else begin
      sample = $signed({2'b00, rdata}) - 10'sd128;
    end
    for (int i = 0; i < LANES; i++) begin
      prod[i] = 18'(sample * $signed({1'b0, lane_depth[i]}));
      quot[i] = (prod[i] < 0) ? ((prod[i] + 18'sd127) >>> 7) : (prod[i] >>> 7);
      sum[i]  = 11'(quot[i]) + $signed({4'b0000, c_base[i]});
      if (sum[i] < 0) begin
        clamped[i] = '0;
      end else if (sum[i] > 11'sd127) begin
        clamped[i] = 7'd127;
      end else begin
        clamped[i] = sum[i][6:0];
      end
    end
  end

  // --- emit stage ---
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      chg[i] = e_vld && e_rem[i] && ({1'b0, e_val[i]} != last_val[i]);
    end
    out_free  = !out_vld || result_out.ready;
    emit_lane = !chg[0];
    emit_last = chg[0] ? !chg[1] : 1'b1;
    emit      = (chg != '0) && out_free;
    e_done    = e_vld && ((chg == '0) || (emit && emit_last));
    e_take    = !e_vld || e_done;
  end

  always_ff @(posedge clk) begin
    if (e_take) begin
      e_rem <= c_act;
      for (int i = 0; i < LANES; i++) begin
        e_val[i] <= clamped[i];
      end
    end else if (emit) begin
      e_rem[emit_lane] <= 1'b0;
    end
    if (emit) begin
      out_data.lane  <= emit_lane;
      out_data.value <= e_val[emit_lane];
      out_data.last  <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld   <= 1'b0;
      e_vld   <= 1'b0;
      out_vld <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        last_val[i] <= LAST_NONE;
      end
    end else begin
      if (pop_tick) begin
        c_vld <= 1'b1;
      end else if (e_take) begin
        c_vld <= 1'b0;
      end
      if (e_take) begin
        e_vld <= c_vld;
      end
      if (emit) begin
        out_vld             <= 1'b1;
        last_val[emit_lane] <= {1'b0, e_val[emit_lane]};
      end else if (result_out.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign result_out.valid = out_vld;
  assign result_out.data  = out_data;
endmodule

// ===== rtl/lfo_sequencer_track_top.sv =====
// ----------------------------------------------------------------------------
// lfo_sequencer_track_top
// Tick-driven wavetable LFO with two modulation lanes and retrigger mask.
// ----------------------------------------------------------------------------
//
//   channel     dir   beat payload                         handshake
//   item_in     in    in_item_t (tick or table byte write) valid/ready
//   result_out  out   out_item_t (lane, value, last)       valid/ready
//   cfg_*       in    register index + 64-bit data         write enable only
//
// Flow: one beat taken per cycle while the four-entry queue has room; a tick
// with both lanes changing yields two output beats. A result passes the queue,
// the registered table read, the registered scaled value and the output register.
// Reset: synchronous; clears sequencer, config, queue and lane history, not the
// wave table, which must be written before it is read.
// Stalls: result_out.ready low fills the queue, then item_in.ready drops.
// ----------------------------------------------------------------------------
module lfo_sequencer_track_top #(
  parameter int TABLE_LENGTH = 128,
  parameter int MAX_STEPS    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  lst_stream_if.sink                       item_in,
  lst_stream_if.source                     result_out,
  input  logic                             cfg_we,
  input  logic [lst_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lst_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lst_pkg::*;

  cfg_t    cfg;
  logic    push;
  qentry_t push_entry;
  logic    queue_full;
  logic    q_valid;
  qentry_t q_head;
  logic    q_pop;

  // Configuration registers; to be written only while the block is idle (the block itself does not enforce this).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_select   <= '0;
      cfg.speed_divider <= '0;
      cfg.lfo_mode      <= '0;
      cfg.retrig_mask   <= '0;
      cfg.track_length  <= TRACK_LENGTH_RESET;
      cfg.output_enable <= 1'b0;
      cfg.depth_a       <= '0;
      cfg.depth_b       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WAVE_SELECT:   cfg.wave_select   <= cfg_data[2:0];
        CFG_SPEED_DIVIDER: cfg.speed_divider <= cfg_data[6:0];
        CFG_LFO_MODE:      cfg.lfo_mode      <= cfg_data[1:0];
        CFG_RETRIG_MASK:   cfg.retrig_mask   <= cfg_data[MASK_W-1:0];
        CFG_TRACK_LENGTH:  cfg.track_length  <= cfg_data[6:0];
        CFG_OUTPUT_ENABLE: cfg.output_enable <= cfg_data[0];
        CFG_DEPTH_A:       cfg.depth_a       <= cfg_data[6:0];
        CFG_DEPTH_B:       cfg.depth_b       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: phase, speed divider and step counter advance at accept time,
  // so each queued tick already carries its lookup phase.
  lst_front #(
    .TABLE_LENGTH (TABLE_LENGTH),
    .MAX_STEPS    (MAX_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (q_pop),
    .nonempty   (q_valid),
    .head       (q_head)
  );

  // Back end: table writes and reads in queue order, one shared sample per
  // tick, per-lane scale, then one result beat per cycle while the output is free.
  lst_back #(
    .TABLE_LENGTH (TABLE_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .result_out (result_out)
  );
endmodule
